[rtl/nearest_neighbor_image_rotator_assert.svh]
// Assertion macros for the nearest-neighbor image rotator.
// Depends on nothing; included by the top level only.
`ifndef NEAREST_NEIGHBOR_IMAGE_ROTATOR_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_ROTATOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define NNR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds after ante, with the delay given by n.
`define NNR_ASSERT_AFTER(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

[rtl/nnr_pkg.sv]
// Shared constants and types of the nearest-neighbor image rotator.
// Depends on nothing; used by nnr_map, nnr_store and the top level.
package nnr_pkg;

   // field widths
   localparam int COORD_BITS     = 8;
   localparam int SIZE_BITS      = 9;
   localparam int ANGLE_BITS     = 16;
   localparam int PIXEL_BITS     = 32;
   localparam int FRAC_BITS      = 14;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // frame store geometry
   localparam int MAX_WIDTH   = 1 << COORD_BITS;
   localparam int MAX_HEIGHT  = 1 << COORD_BITS;
   localparam int ADDR_BITS   = 2 * COORD_BITS;
   localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;

   // mapping arithmetic
   localparam int MID_BITS  = SIZE_BITS - 1;
   localparam int OFF_BITS  = SIZE_BITS + 1;
   localparam int PROD_BITS = OFF_BITS + ANGLE_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;
   localparam int INT_BITS  = SUM_BITS - FRAC_BITS;

   // commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COS_ANGLE    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SIN_ANGLE    = 2'd3;

   // register reset values
   localparam logic [SIZE_BITS-1:0]  RESET_WIDTH  = 9'd256;
   localparam logic [SIZE_BITS-1:0]  RESET_HEIGHT = 9'd256;
   localparam logic [ANGLE_BITS-1:0] RESET_COS    = 16'd16384;
   localparam logic [ANGLE_BITS-1:0] RESET_SIN    = 16'd0;

   // clamped geometry and angle as seen by the mapping pipeline
   typedef struct packed {
      logic [SIZE_BITS-1:0]         width_eff;
      logic [SIZE_BITS-1:0]         height_eff;
      logic [MID_BITS-1:0]          mid_w;
      logic [MID_BITS-1:0]          mid_h;
      logic signed [ANGLE_BITS-1:0] cos_angle;
      logic signed [ANGLE_BITS-1:0] sin_angle;
   } cfg_type;

   // one frame store access handed from the mapper to the store
   typedef struct packed {
      logic                  valid;
      logic                  write;
      logic                  in_image;
      logic [ADDR_BITS-1:0]  addr;
      logic [PIXEL_BITS-1:0] pixel;
   } access_type;

endpackage

[rtl/nnr_map.sv]
// Coordinate mapping pipeline: offsets, products, sums, truncation and bounds.
// Depends on nnr_pkg; feeds one access per item to nnr_store.
module nnr_map (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 command,
   input  logic [nnr_pkg::COORD_BITS-1:0]       row,
   input  logic [nnr_pkg::COORD_BITS-1:0]       col,
   input  logic [nnr_pkg::PIXEL_BITS-1:0]       pixel_in,
   input  nnr_pkg::cfg_type                     cfg,
   output nnr_pkg::access_type                  access
);

   // truncate a fixed-point position toward zero and check it against the size;
   // returns {in_image, index}
   function automatic logic [nnr_pkg::COORD_BITS:0] map_axis(
      input logic signed [nnr_pkg::SUM_BITS-1:0] pos,
      input logic [nnr_pkg::SIZE_BITS-1:0]       size
   );
      logic [nnr_pkg::INT_BITS-1:0]   whole;
      logic [nnr_pkg::FRAC_BITS-1:0]  frac;
      logic                           ok;
      logic [nnr_pkg::COORD_BITS-1:0] idx;
      whole = pos[nnr_pkg::SUM_BITS-1:nnr_pkg::FRAC_BITS];
      frac  = pos[nnr_pkg::FRAC_BITS-1:0];
      if (pos[nnr_pkg::SUM_BITS-1]) begin
         // only a value in (-1, 0) truncates to zero
         ok  = (whole == '1) && (frac != '0);
         idx = '0;
      end else begin
         ok  = whole < nnr_pkg::INT_BITS'(size);
         idx = whole[nnr_pkg::COORD_BITS-1:0];
      end
      return {ok, idx};
   endfunction

   // stage 1: offsets from the center
   logic                                 s1_valid_ff;
   logic                                 s1_write_ff;
   logic                                 s1_range_ff;
   logic [nnr_pkg::ADDR_BITS-1:0]        s1_addr_ff;
   logic [nnr_pkg::PIXEL_BITS-1:0]       s1_pixel_ff;
   logic signed [nnr_pkg::OFF_BITS-1:0]  s1_di_ff;
   logic signed [nnr_pkg::OFF_BITS-1:0]  s1_dj_ff;
   logic signed [nnr_pkg::OFF_BITS-1:0]  di_in;
   logic signed [nnr_pkg::OFF_BITS-1:0]  dj_in;
   logic                                 range_in;

   // stage 2: products
   logic                                 s2_valid_ff;
   logic                                 s2_write_ff;
   logic                                 s2_range_ff;
   logic [nnr_pkg::ADDR_BITS-1:0]        s2_addr_ff;
   logic [nnr_pkg::PIXEL_BITS-1:0]       s2_pixel_ff;
   logic signed [nnr_pkg::PROD_BITS-1:0] s2_dic_ff;
   logic signed [nnr_pkg::PROD_BITS-1:0] s2_djs_ff;
   logic signed [nnr_pkg::PROD_BITS-1:0] s2_djc_ff;
   logic signed [nnr_pkg::PROD_BITS-1:0] s2_dis_ff;

   // stage 3: source positions
   logic                                 s3_valid_ff;
   logic                                 s3_write_ff;
   logic                                 s3_range_ff;
   logic [nnr_pkg::ADDR_BITS-1:0]        s3_addr_ff;
   logic [nnr_pkg::PIXEL_BITS-1:0]       s3_pixel_ff;
   logic signed [nnr_pkg::SUM_BITS-1:0]  s3_sx_ff;
   logic signed [nnr_pkg::SUM_BITS-1:0]  s3_sy_ff;
   logic signed [nnr_pkg::SUM_BITS-1:0]  sx_in;
   logic signed [nnr_pkg::SUM_BITS-1:0]  sy_in;
   logic signed [nnr_pkg::SUM_BITS-1:0]  mid_h_fix;
   logic signed [nnr_pkg::SUM_BITS-1:0]  mid_w_fix;

   // stage 4: access to the store
   nnr_pkg::access_type                  access_ff;
   nnr_pkg::access_type                  access_in;
   logic [nnr_pkg::COORD_BITS:0]         x_map;
   logic [nnr_pkg::COORD_BITS:0]         y_map;

   // form offsets and the in-image check of the output position
   always_comb begin
      di_in = $signed({{(nnr_pkg::OFF_BITS - nnr_pkg::COORD_BITS){1'b0}}, row})
            - $signed({{(nnr_pkg::OFF_BITS - nnr_pkg::MID_BITS){1'b0}}, cfg.mid_h});
      dj_in = $signed({{(nnr_pkg::OFF_BITS - nnr_pkg::COORD_BITS){1'b0}}, col})
            - $signed({{(nnr_pkg::OFF_BITS - nnr_pkg::MID_BITS){1'b0}}, cfg.mid_w});
      range_in = (nnr_pkg::SIZE_BITS'(row) < cfg.height_eff)
              && (nnr_pkg::SIZE_BITS'(col) < cfg.width_eff);
   end

   // form the two source positions with the center folded in
   always_comb begin
      mid_h_fix = $signed({{(nnr_pkg::SUM_BITS - nnr_pkg::FRAC_BITS - nnr_pkg::MID_BITS){1'b0}},
                           cfg.mid_h, {nnr_pkg::FRAC_BITS{1'b0}}});
      mid_w_fix = $signed({{(nnr_pkg::SUM_BITS - nnr_pkg::FRAC_BITS - nnr_pkg::MID_BITS){1'b0}},
                           cfg.mid_w, {nnr_pkg::FRAC_BITS{1'b0}}});
      sx_in = mid_h_fix + nnr_pkg::SUM_BITS'(s2_dic_ff) - nnr_pkg::SUM_BITS'(s2_djs_ff);
      sy_in = mid_w_fix + nnr_pkg::SUM_BITS'(s2_djc_ff) + nnr_pkg::SUM_BITS'(s2_dis_ff);
   end

   // truncate, bound and build the store access
   always_comb begin
      x_map              = map_axis(s3_sx_ff, cfg.height_eff);
      y_map              = map_axis(s3_sy_ff, cfg.width_eff);
      access_in.valid    = s3_valid_ff;
      access_in.write    = s3_write_ff;
      access_in.in_image = s3_range_ff && x_map[nnr_pkg::COORD_BITS]
                        && y_map[nnr_pkg::COORD_BITS];
      access_in.pixel    = s3_pixel_ff;
      if (s3_write_ff) begin
         access_in.addr = s3_addr_ff;
      end else begin
         access_in.addr = {x_map[nnr_pkg::COORD_BITS-1:0], y_map[nnr_pkg::COORD_BITS-1:0]};
      end
   end

   // advance the valid markers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      s1_write_ff      <= (command == nnr_pkg::CMD_WRITE);
      s1_range_ff      <= range_in;
      s1_addr_ff       <= {row, col};
      s1_pixel_ff      <= pixel_in;
      s1_di_ff         <= di_in;
      s1_dj_ff         <= dj_in;

      s2_write_ff      <= s1_write_ff;
      s2_range_ff      <= s1_range_ff;
      s2_addr_ff       <= s1_addr_ff;
      s2_pixel_ff      <= s1_pixel_ff;
      s2_dic_ff        <= s1_di_ff * cfg.cos_angle;
      s2_djs_ff        <= s1_dj_ff * cfg.sin_angle;
      s2_djc_ff        <= s1_dj_ff * cfg.cos_angle;
      s2_dis_ff        <= s1_di_ff * cfg.sin_angle;

      s3_write_ff      <= s2_write_ff;
      s3_range_ff      <= s2_range_ff;
      s3_addr_ff       <= s2_addr_ff;
      s3_pixel_ff      <= s2_pixel_ff;
      s3_sx_ff         <= sx_in;
      s3_sy_ff         <= sy_in;
   end

   // register the store access
   always_ff @(posedge clock) begin
      if (reset) begin
         access_ff.valid <= 1'b0;
      end else begin
         access_ff.valid <= access_in.valid;
      end
      access_ff.write    <= access_in.write;
      access_ff.in_image <= access_in.in_image;
      access_ff.addr     <= access_in.addr;
      access_ff.pixel    <= access_in.pixel;
   end

   assign access = access_ff;

endmodule

[rtl/nnr_store.sv]
// Frame store: one synchronous single-port memory and the result register.
// Depends on nnr_pkg; takes accesses in item order from nnr_map.
module nnr_store (
   input  logic                           clock,
   input  logic                           reset,
   input  nnr_pkg::access_type            access,
   output logic                           rsp_strobe,
   output logic [nnr_pkg::PIXEL_BITS-1:0] rsp_pixel_out,
   output logic                           rsp_inside_res
);

   logic [nnr_pkg::PIXEL_BITS-1:0] mem [nnr_pkg::STORE_WORDS];
   logic [nnr_pkg::PIXEL_BITS-1:0] rd_data_ff;
   logic                           strobe_ff;
   logic                           inside_ff;

   // write a source pixel or read the mapped one, one access per cycle
   always_ff @(posedge clock) begin
      if (access.valid && access.write) begin
         mem[access.addr] <= access.pixel;
      end
      if (access.valid && !access.write && access.in_image) begin
         rd_data_ff <= mem[access.addr];
      end
   end

   // mark a result for each read
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         inside_ff <= 1'b0;
      end else begin
         strobe_ff <= access.valid && !access.write;
         inside_ff <= access.valid && !access.write && access.in_image;
      end
   end

   // drop the data to black when the position fell outside
   assign rsp_strobe     = strobe_ff;
   assign rsp_inside_res = inside_ff;
   assign rsp_pixel_out  = inside_ff ? rd_data_ff : '0;

endmodule

[rtl/nearest_neighbor_image_rotator.sv]
// Top level of the nearest-neighbor image rotator: registers, mapper, store.
// Depends on nnr_pkg, nnr_map, nnr_store and nearest_neighbor_image_rotator_assert.svh.
//
//   channel  ports                                        transfer when
//   request  start, busy, req_command/row/col/pixel_in    start && !busy
//   result   rsp_strobe, rsp_pixel_out, rsp_inside_res    rsp_strobe
//   config   csr_write_enable, csr_index, csr_write_data  csr_write_enable
//
// One item enters per cycle while busy is low; a read passes the offsets, products,
// sums and bounds stages and then the single memory read before its result is on
// the ports, where it is taken when rsp_strobe is high. The receiver cannot stall.
// Writes take the same path and use the same memory port, so items stay in order.
// busy is high only during reset and the cycle after it.
// The store holds no reset; only pipeline valid markers and registers clear.
module nearest_neighbor_image_rotator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_command,
   input  logic [nnr_pkg::COORD_BITS-1:0]     req_row,
   input  logic [nnr_pkg::COORD_BITS-1:0]     req_col,
   input  logic [nnr_pkg::PIXEL_BITS-1:0]     req_pixel_in,
   output logic                               rsp_strobe,
   output logic [nnr_pkg::PIXEL_BITS-1:0]     rsp_pixel_out,
   output logic                               rsp_inside_res,
   input  logic                               csr_write_enable,
   input  logic [nnr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [nnr_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   `include "nearest_neighbor_image_rotator_assert.svh"

   logic [nnr_pkg::SIZE_BITS-1:0]  width_ff;
   logic [nnr_pkg::SIZE_BITS-1:0]  height_ff;
   logic [nnr_pkg::ANGLE_BITS-1:0] cos_ff;
   logic [nnr_pkg::ANGLE_BITS-1:0] sin_ff;
   logic                           busy_ff;
   logic                           accept;
   logic                           read_xfer;
   logic                           outside_rsp;
   nnr_pkg::cfg_type               cfg;
   nnr_pkg::access_type            access;

   // hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= nnr_pkg::RESET_WIDTH;
         height_ff <= nnr_pkg::RESET_HEIGHT;
         cos_ff    <= nnr_pkg::RESET_COS;
         sin_ff    <= nnr_pkg::RESET_SIN;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            nnr_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_write_data[nnr_pkg::SIZE_BITS-1:0];
            nnr_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_write_data[nnr_pkg::SIZE_BITS-1:0];
            nnr_pkg::REG_COS_ANGLE:    cos_ff    <= csr_write_data;
            nnr_pkg::REG_SIN_ANGLE:    sin_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // hold off transfers until reset is over
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // clamp the sizes into the store and derive the center
   always_comb begin
      if (width_ff == '0) begin
         cfg.width_eff = nnr_pkg::SIZE_BITS'(1);
      end else if (width_ff > nnr_pkg::SIZE_BITS'(nnr_pkg::MAX_WIDTH)) begin
         cfg.width_eff = nnr_pkg::SIZE_BITS'(nnr_pkg::MAX_WIDTH);
      end else begin
         cfg.width_eff = width_ff;
      end
      if (height_ff == '0) begin
         cfg.height_eff = nnr_pkg::SIZE_BITS'(1);
      end else if (height_ff > nnr_pkg::SIZE_BITS'(nnr_pkg::MAX_HEIGHT)) begin
         cfg.height_eff = nnr_pkg::SIZE_BITS'(nnr_pkg::MAX_HEIGHT);
      end else begin
         cfg.height_eff = height_ff;
      end
      cfg.mid_w     = cfg.width_eff[nnr_pkg::SIZE_BITS-1:1];
      cfg.mid_h     = cfg.height_eff[nnr_pkg::SIZE_BITS-1:1];
      cfg.cos_angle = $signed(cos_ff);
      cfg.sin_angle = $signed(sin_ff);
   end

   nnr_map u_map (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .command  (req_command),
      .row      (req_row),
      .col      (req_col),
      .pixel_in (req_pixel_in),
      .cfg      (cfg),
      .access   (access)
   );

   nnr_store u_store (
      .clock          (clock),
      .reset          (reset),
      .access         (access),
      .rsp_strobe     (rsp_strobe),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_inside_res (rsp_inside_res)
   );

   assign read_xfer   = accept && (req_command == nnr_pkg::CMD_READ);
   assign outside_rsp = rsp_strobe && !rsp_inside_res;

   // every read transfer yields one result on the result ports
   `NNR_ASSERT_AFTER(a_read_gives_result, clock, reset, read_xfer, 5, rsp_strobe, "read lost")

   // no result without an earlier read transfer
   `NNR_ASSERT_IMPLIES(a_result_has_read, clock, reset, rsp_strobe, $past(read_xfer, 5), "stray result")

   // outside positions give black
   `NNR_ASSERT_IMPLIES(a_outside_black, clock, reset, outside_rsp, rsp_pixel_out == '0, "not black")

endmodule

[tb/nnr_checker.sv]
// Checker of the nearest-neighbor image rotator: watches the request, result and
// register ports, predicts each rotated pixel and compares. Depends on nnr_pkg.
module nnr_checker
   import nnr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_command,
   input  logic [COORD_BITS-1:0]     req_row,
   input  logic [COORD_BITS-1:0]     req_col,
   input  logic [PIXEL_BITS-1:0]     req_pixel_in,
   input  logic                      rsp_strobe,
   input  logic [PIXEL_BITS-1:0]     rsp_pixel_out,
   input  logic                      rsp_inside_res,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output int                        error_count,
   output int                        pending_count,
   output int                        checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  in_image;
   } rotated_pixel_type;

   localparam longint UNIT = longint'(1) << FRAC_BITS;

   // shadow frame store and registers
   logic [PIXEL_BITS-1:0] frame [STORE_WORDS];
   logic [SIZE_BITS-1:0]  width_reg  = RESET_WIDTH;
   logic [SIZE_BITS-1:0]  height_reg = RESET_HEIGHT;
   logic [ANGLE_BITS-1:0] cos_reg    = RESET_COS;
   logic [ANGLE_BITS-1:0] sin_reg    = RESET_SIN;

   rotated_pixel_type rotated_q[$];
   int errors  = 0;
   int checked = 0;

   function automatic longint clamp_size(logic [SIZE_BITS-1:0] v, longint limit);
      longint s;
      s = longint'(v);
      if (s < 1) s = 1;
      if (s > limit) s = limit;
      return s;
   endfunction

   // Map an output pixel back to its source position and look it up.
   function automatic rotated_pixel_type rotate_lookup(logic [COORD_BITS-1:0] row,
                                                       logic [COORD_BITS-1:0] col);
      longint w, h, cs, sn, mid_w, mid_h, di, dj, sx, sy, x, y;
      rotated_pixel_type res;
      res   = '0;
      w     = clamp_size(width_reg, MAX_WIDTH);
      h     = clamp_size(height_reg, MAX_HEIGHT);
      cs    = longint'($signed(cos_reg));
      sn    = longint'($signed(sin_reg));
      mid_w = w / 2;
      mid_h = h / 2;
      if (longint'(row) < h && longint'(col) < w) begin
         di = longint'(row) - mid_h;
         dj = longint'(col) - mid_w;
         sx = mid_h * UNIT + di * cs - dj * sn;
         sy = mid_w * UNIT + dj * cs + di * sn;
         // signed division truncates toward zero
         x  = sx / UNIT;
         y  = sy / UNIT;
         if (x >= 0 && x < h && y >= 0 && y < w) begin
            res.in_image = 1'b1;
            res.pixel    = frame[int'(x) * MAX_WIDTH + int'(y)];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rotated_pixel_type want;
      if (reset) begin
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         cos_reg    = RESET_COS;
         sin_reg    = RESET_SIN;
         rotated_q.delete();
      end else begin
         // track register writes
         if (csr_write_enable) begin
            case (csr_index)
               REG_IMAGE_WIDTH:  width_reg  = csr_write_data[SIZE_BITS-1:0];
               REG_IMAGE_HEIGHT: height_reg = csr_write_data[SIZE_BITS-1:0];
               REG_COS_ANGLE:    cos_reg    = csr_write_data[ANGLE_BITS-1:0];
               REG_SIN_ANGLE:    sin_reg    = csr_write_data[ANGLE_BITS-1:0];
               default: ;
            endcase
         end

         // compare each result with the oldest prediction
         if (rsp_strobe) begin
            if (rotated_q.size() == 0) begin
               errors++;
               $display("%0t: result with no read waiting: pixel %h inside %b",
                        $time, rsp_pixel_out, rsp_inside_res);
            end else begin
               want = rotated_q.pop_front();
               checked++;
               if (rsp_pixel_out !== want.pixel) begin
                  errors++;
                  $display("%0t: pixel_out mismatch: expected %h, actual %h",
                           $time, want.pixel, rsp_pixel_out);
               end
               if (rsp_inside_res !== want.in_image) begin
                  errors++;
                  $display("%0t: inside_res mismatch: expected %b, actual %b",
                           $time, want.in_image, rsp_inside_res);
               end
            end
         end

         // store writes, predict reads on each request transfer
         if (start && !busy) begin
            if (req_command == CMD_WRITE)
               frame[{req_row, req_col}] = req_pixel_in;
            else
               rotated_q.push_back(rotate_lookup(req_row, req_col));
         end
      end
      error_count   <= errors;
      pending_count <= rotated_q.size();
      checked_count <= checked;
   end

endmodule

[tb/tb_nearest_neighbor_image_rotator.sv]
// Top of the image rotator testbench: clock, reset, register settings and pixel
// traffic. Depends on nnr_pkg, nnr_checker and the nearest_neighbor_image_rotator RTL.
module tb_nearest_neighbor_image_rotator;
   timeunit 1ns;
   timeprecision 1ps;
   import nnr_pkg::*;

   localparam longint UNIT = longint'(1) << FRAC_BITS;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      start            = 1'b0;
   logic                      busy;
   logic                      req_command      = CMD_WRITE;
   logic [COORD_BITS-1:0]     req_row          = '0;
   logic [COORD_BITS-1:0]     req_col          = '0;
   logic [PIXEL_BITS-1:0]     req_pixel_in     = '0;
   logic                      rsp_strobe;
   logic [PIXEL_BITS-1:0]     rsp_pixel_out;
   logic                      rsp_inside_res;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data   = '0;

   int error_count;
   int pending_count;
   int checked_count;

   // stimulus bookkeeping
   bit written_map [STORE_WORDS];
   int burst_left    = 0;
   int write_count   = 0;
   int read_count    = 0;
   int setting_count = 0;
   int width_eff     = MAX_WIDTH;
   int height_eff    = MAX_HEIGHT;
   longint cos_cur   = 16384;
   longint sin_cur   = 0;

   always #5 clock = ~clock;

   nearest_neighbor_image_rotator dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_pixel_in     (req_pixel_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_inside_res   (rsp_inside_res),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   nnr_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_pixel_in     (req_pixel_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_inside_res   (rsp_inside_res),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count)
   );

   function automatic int clamp_size(logic [SIZE_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_WIDTH) return MAX_WIDTH;
      return int'(v);
   endfunction

   // Source entry that a read of (row, col) lands on, or -1 when it maps outside.
   function automatic int map_source(logic [COORD_BITS-1:0] row,
                                     logic [COORD_BITS-1:0] col);
      longint mid_w, mid_h, di, dj, sx, sy, x, y;
      if (int'(row) >= height_eff || int'(col) >= width_eff) return -1;
      mid_w = longint'(width_eff / 2);
      mid_h = longint'(height_eff / 2);
      di    = longint'(row) - mid_h;
      dj    = longint'(col) - mid_w;
      sx    = mid_h * UNIT + di * cos_cur - dj * sin_cur;
      sy    = mid_w * UNIT + dj * cos_cur + di * sin_cur;
      x     = sx / UNIT;
      y     = sy / UNIT;
      if (x < 0 || x >= height_eff || y < 0 || y >= width_eff) return -1;
      return int'(x) * MAX_WIDTH + int'(y);
   endfunction

   // Transfer one item; open a new burst after a random gap when the old one ends.
   task automatic send_item(input logic cmd, input logic [COORD_BITS-1:0] row,
                            input logic [COORD_BITS-1:0] col,
                            input logic [PIXEL_BITS-1:0] pix);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96)
                                                  : $urandom_range(1, 12);
      end
      start        <= 1'b1;
      req_command  <= cmd;
      req_row      <= row;
      req_col      <= col;
      req_pixel_in <= pix;
      do @(posedge clock); while (busy);
      burst_left--;
      if (cmd == CMD_WRITE) begin
         written_map[{row, col}] = 1'b1;
         write_count++;
      end else begin
         read_count++;
      end
   endtask

   // Read one rotated pixel; first write its source entry if it was never written.
   task automatic read_item(input logic [COORD_BITS-1:0] row,
                            input logic [COORD_BITS-1:0] col);
      int src;
      src = map_source(row, col);
      if (src >= 0 && !written_map[src])
         send_item(CMD_WRITE, COORD_BITS'(src / MAX_WIDTH), COORD_BITS'(src % MAX_WIDTH),
                   $urandom);
      send_item(CMD_READ, row, col, '0);
   endtask

   // Drop start, drain all reads, then let trailing writes leave the pipeline.
   task automatic wait_idle();
      start      <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] wdata,
                            input logic [CSR_DATA_BITS-1:0] hdata,
                            input logic [ANGLE_BITS-1:0] cos_val,
                            input logic [ANGLE_BITS-1:0] sin_val);
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, wdata);
      write_reg(REG_IMAGE_HEIGHT, hdata);
      write_reg(REG_COS_ANGLE, cos_val);
      write_reg(REG_SIN_ANGLE, sin_val);
      csr_write_enable <= 1'b0;
      width_eff  = clamp_size(wdata[SIZE_BITS-1:0]);
      height_eff = clamp_size(hdata[SIZE_BITS-1:0]);
      cos_cur    = longint'($signed(cos_val));
      sin_cur    = longint'($signed(sin_val));
      setting_count++;
   endtask

   // Mostly reads inside the image in use, with rewrites and stray coordinates.
   task automatic random_items(input int count);
      logic [COORD_BITS-1:0] row, col;
      logic                  cmd;
      repeat (count) begin
         cmd = ($urandom_range(0, 99) < 65) ? CMD_READ : CMD_WRITE;
         row = ($urandom_range(0, 4) == 0) ? COORD_BITS'($urandom)
                                           : COORD_BITS'($urandom_range(0, height_eff - 1));
         col = ($urandom_range(0, 4) == 0) ? COORD_BITS'($urandom)
                                           : COORD_BITS'($urandom_range(0, width_eff - 1));
         if (cmd == CMD_WRITE && $urandom_range(0, 1) == 0) begin
            row = COORD_BITS'($urandom);
            col = COORD_BITS'($urandom);
         end
         if (cmd == CMD_READ)
            read_item(row, col);
         else
            send_item(CMD_WRITE, row, col, $urandom);
      end
   endtask

   function automatic logic [SIZE_BITS-1:0] pick_size();
      case ($urandom_range(0, 9))
         6:       return SIZE_BITS'(MAX_WIDTH);
         7:       return SIZE_BITS'($urandom_range(17, 255));
         8:       return '0;
         9:       return SIZE_BITS'($urandom_range(257, 511));
         default: return SIZE_BITS'($urandom_range(1, 16));
      endcase
   endfunction

   task automatic pick_angle(output logic [ANGLE_BITS-1:0] cos_val,
                             output logic [ANGLE_BITS-1:0] sin_val);
      case ($urandom_range(0, 7))
         0: begin cos_val = 16'h4000; sin_val = 16'h0000; end
         1: begin cos_val = 16'hC000; sin_val = 16'h0000; end
         2: begin cos_val = 16'h0000; sin_val = 16'h4000; end
         3: begin cos_val = 16'h0000; sin_val = 16'hC000; end
         4: begin cos_val = 16'h2D41; sin_val = 16'hD2BF; end
         5: begin
            cos_val = ANGLE_BITS'($urandom_range(0, 32768) - 16384);
            sin_val = ANGLE_BITS'($urandom_range(0, 32768) - 16384);
         end
         default: begin
            cos_val = ANGLE_BITS'($urandom);
            sin_val = ANGLE_BITS'($urandom);
         end
      endcase
   endtask

   initial begin
      logic [ANGLE_BITS-1:0] cos_val, sin_val;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset setting: full size, identity, corners map onto themselves
      send_item(CMD_WRITE, 8'd0,   8'd0,   32'h0000_0000);
      send_item(CMD_WRITE, 8'd0,   8'd255, 32'hFFFF_FFFF);
      send_item(CMD_WRITE, 8'd255, 8'd0,   32'hA5A5_A5A5);
      send_item(CMD_WRITE, 8'd255, 8'd255, 32'h5A5A_5A5A);
      read_item(8'd0,   8'd0);
      read_item(8'd0,   8'd255);
      read_item(8'd255, 8'd0);
      read_item(8'd255, 8'd255);

      // 8x8, cos just over one: the corner maps slightly negative and truncates to 0
      configure(16'd8, 16'd8, 16'h4001, 16'h0000);
      read_item(8'd0,   8'd0);
      read_item(8'd7,   8'd7);
      read_item(8'd8,   8'd3);
      read_item(8'd3,   8'd200);
      read_item(8'd255, 8'd255);
      random_items(30);

      // width 0 taken as 1, height over range taken as 256, quarter turn
      configure(16'hFE00, 16'hFFFF, 16'h0000, 16'h4000);
      read_item(8'd0,   8'd0);
      read_item(8'd128, 8'd0);
      read_item(8'd255, 8'd0);
      random_items(30);

      // full size at 45 degrees
      configure(16'd256, 16'd256, 16'h2D41, 16'h2D41);
      read_item(8'd0,   8'd0);
      read_item(8'd0,   8'd255);
      read_item(8'd128, 8'd128);
      random_items(100);

      // half turn: row 0 maps just past the bottom edge
      configure(16'd256, 16'd256, 16'hC000, 16'h0000);
      read_item(8'd0, 8'd0);
      read_item(8'd1, 8'd1);
      random_items(40);

      // single pixel with the most extreme raw angle codes
      configure(16'd1, 16'd1, 16'h7FFF, 16'h8000);
      read_item(8'd0, 8'd0);
      read_item(8'd0, 8'd1);
      random_items(20);

      configure(16'd256, 16'd1, 16'hC000, 16'hC000);
      random_items(30);

      // random geometry and angle, with stray upper bits in the size registers
      repeat (8) begin
         pick_angle(cos_val, sin_val);
         configure({7'($urandom), pick_size()}, {7'($urandom), pick_size()},
                   cos_val, sin_val);
         random_items(40);
      end

      // drain the pipeline and leave a margin for stray results
      start <= 1'b0;
      for (int k = 0; k < 200 && pending_count != 0; k++) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Ran %0d pixel writes and %0d rotated reads over %0d register settings.",
               write_count, read_count, setting_count + 1);
      $display("%0d rotated pixels compared; sizes 1 to 256 with clamping,", checked_count);
      $display("right, diagonal and raw angles.");
      if (pending_count != 0)
         $display("%0d predicted results never arrived", pending_count);
      if (error_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #(30_000_000);
      $display("Timeout: stimulus or results stalled");
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/nnr_pkg.sv
rtl/nnr_map.sv
rtl/nnr_store.sv
rtl/nearest_neighbor_image_rotator.sv
tb/nnr_checker.sv
tb/tb_nearest_neighbor_image_rotator.sv
